// ===== hdl/skf_pkg.sv =====
package skf_pkg;

  // Field widths
  localparam int AngleWidth = 16;
  localparam int CovWidth   = 16;
  localparam int GainWidth  = 17;
  localparam int GainFrac   = 16;

  // Shared multiplier: signed operands wide enough for the gain and the angle difference
  localparam int MulWidth  = ((AngleWidth + 1 > GainWidth) ? AngleWidth + 1 : GainWidth) + 1;
  localparam int ProdWidth = 2 * MulWidth;

  // Divider: remainder holds up to twice the denominator, quotient is the gain
  localparam int SumWidth  = CovWidth + 1;
  localparam int RemWidth  = SumWidth + 1;
  localparam int DivSteps  = GainWidth;
  localparam int StepWidth = $clog2(DivSteps + 1);

  localparam logic [GainWidth-1:0] GainOne = GainWidth'(1) << GainFrac;

  // Configuration register indexes
  localparam int CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] RegProcessNoise     = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegMeasurementNoise = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegErrorPreset      = 2'd2;

  typedef struct packed {
    logic signed [AngleWidth-1:0] measurement;
    logic                         reload_error;
  } sample_beat_t;

  typedef struct packed {
    logic signed [AngleWidth-1:0] estimate;
    logic        [GainWidth-1:0]  gain;
    logic        [CovWidth-1:0]   error_covariance;
  } result_beat_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic predict;
    logic div_init;
    logic div_step;
    logic mul_est;
    logic upd_est;
    logic mul_cov;
    logic upd_cov;
    logic out_load;
  } skf_cmd_t;

endpackage

// ===== hdl/skf_ctrl.sv =====
module skf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  output logic              result_valid,
  input  logic              result_ready,
  output skf_pkg::skf_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DIV_INIT,
    DIV_STEP,
    MUL_EST,
    UPD_EST,
    MUL_COV,
    UPD_COV,
    DONE
  } state_t;

  state_t                            state;
  logic [skf_pkg::StepWidth-1:0]     step;
  logic                              out_free;

  assign sample_ready = (state == IDLE);
  assign out_free     = !result_valid || result_ready;

  // Decode commands from the current state
  always_comb begin
    cmd          = '0;
    cmd.predict  = (state == IDLE) && sample_valid;
    cmd.div_init = (state == DIV_INIT);
    cmd.div_step = (state == DIV_STEP);
    cmd.mul_est  = (state == MUL_EST);
    cmd.upd_est  = (state == UPD_EST);
    cmd.mul_cov  = (state == MUL_COV);
    cmd.upd_cov  = (state == UPD_COV);
    cmd.out_load = (state == DONE) && out_free;
  end

  // Sequence one sample through divide, estimate update and covariance update
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      // Raise the result beat on load, drop it once taken
      if ((state == DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (sample_valid) begin
            state <= DIV_INIT;
          end
        end
        DIV_INIT: begin
          step  <= '0;
          state <= DIV_STEP;
        end
        DIV_STEP: begin
          step <= step + 1'b1;
          if (step == skf_pkg::StepWidth'(skf_pkg::DivSteps - 1)) begin
            state <= MUL_EST;
          end
        end
        MUL_EST: state <= UPD_EST;
        UPD_EST: state <= MUL_COV;
        MUL_COV: state <= UPD_COV;
        UPD_COV: state <= DONE;
        DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/skf_datapath.sv =====
module skf_datapath #(
  parameter int COV_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  skf_pkg::skf_cmd_t                   cmd,
  input  skf_pkg::sample_beat_t               sample,
  input  logic                                cfg_we,
  input  logic [skf_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [skf_pkg::CovWidth-1:0]        cfg_data,
  output skf_pkg::result_beat_t               result
);

  localparam logic [skf_pkg::CovWidth-1:0] CovTenth =
    skf_pkg::CovWidth'(((1 << COV_FRAC_BITS) + 5) / 10);

  // Configuration registers
  logic [skf_pkg::CovWidth-1:0] process_noise;
  logic [skf_pkg::CovWidth-1:0] measurement_noise;
  logic [skf_pkg::CovWidth-1:0] error_preset;

  // Filter state
  logic signed [skf_pkg::AngleWidth-1:0] est;
  logic        [skf_pkg::CovWidth-1:0]   cov;

  // Working registers
  logic signed [skf_pkg::AngleWidth-1:0] meas;
  logic        [skf_pkg::CovWidth-1:0]   p_pred;
  logic        [skf_pkg::SumWidth-1:0]   s_sum;
  logic        [skf_pkg::RemWidth-1:0]   rem;
  logic        [skf_pkg::GainWidth-1:0]  quot;
  logic signed [skf_pkg::ProdWidth-1:0]  prod;

  logic [skf_pkg::CovWidth-1:0]        p_start;
  logic [skf_pkg::SumWidth-1:0]        p_sum;
  logic [skf_pkg::RemWidth-1:0]        rem_sub;
  logic                                rem_ge;
  logic [skf_pkg::GainWidth-1:0]       gain;
  logic [skf_pkg::GainWidth-1:0]       one_minus_gain;
  logic signed [skf_pkg::AngleWidth:0] diff;
  logic signed [skf_pkg::MulWidth-1:0] mul_a;
  logic signed [skf_pkg::MulWidth-1:0] mul_b;

  // Predict: optional reload, then saturating add of process noise
  assign p_start = sample.reload_error ? error_preset : cov;
  assign p_sum   = {1'b0, p_start} + {1'b0, process_noise};

  // Restoring division step
  assign rem_sub = rem - {1'b0, s_sum};
  assign rem_ge  = (rem >= {1'b0, s_sum});

  // Zero denominator gives zero gain
  assign gain           = (s_sum == '0) ? '0 : quot;
  assign one_minus_gain = skf_pkg::GainOne - gain;

  assign diff = {meas[skf_pkg::AngleWidth-1], meas} - {est[skf_pkg::AngleWidth-1], est};

  // Shared multiplier operands
  always_comb begin
    if (cmd.mul_cov) begin
      mul_a = $signed({{(skf_pkg::MulWidth - skf_pkg::GainWidth){1'b0}}, one_minus_gain});
      mul_b = $signed({{(skf_pkg::MulWidth - skf_pkg::CovWidth){1'b0}}, p_pred});
    end else begin
      mul_a = $signed({{(skf_pkg::MulWidth - skf_pkg::GainWidth){1'b0}}, gain});
      mul_b = $signed({{(skf_pkg::MulWidth - skf_pkg::AngleWidth - 1){diff[skf_pkg::AngleWidth]}},
                       diff});
    end
  end

  // Configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= CovTenth;
      measurement_noise <= CovTenth;
      error_preset      <= CovTenth;
      est               <= '0;
      cov               <= CovTenth;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          skf_pkg::RegProcessNoise:     process_noise     <= cfg_data;
          skf_pkg::RegMeasurementNoise: measurement_noise <= cfg_data;
          skf_pkg::RegErrorPreset:      error_preset      <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.upd_est) begin
        est <= est + prod[skf_pkg::GainFrac +: skf_pkg::AngleWidth];
      end
      if (cmd.upd_cov) begin
        cov <= prod[skf_pkg::GainFrac +: skf_pkg::CovWidth];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.predict) begin
      meas   <= sample.measurement;
      p_pred <= p_sum[skf_pkg::CovWidth] ? '1 : p_sum[skf_pkg::CovWidth-1:0];
    end
    if (cmd.div_init) begin
      s_sum <= {1'b0, p_pred} + {1'b0, measurement_noise};
      rem   <= {2'b00, p_pred};
      quot  <= '0;
    end
    if (cmd.div_step) begin
      rem  <= rem_ge ? {rem_sub[skf_pkg::RemWidth-2:0], 1'b0}
                     : {rem[skf_pkg::RemWidth-2:0], 1'b0};
      quot <= {quot[skf_pkg::GainWidth-2:0], rem_ge};
    end
    if (cmd.mul_est || cmd.mul_cov) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.out_load) begin
      result.estimate         <= est;
      result.gain             <= gain;
      result.error_covariance <= cov;
    end
  end

endmodule

// ===== hdl/scalar_kalman_filter_core.sv =====
// States: DIV_INIT, the 17-step restoring divider for the gain (DIV_STEP), then two
// passes through one shared 18x18 multiplier (MUL_EST/UPD_EST, MUL_COV/UPD_COV), DONE.
// DONE holds until the output register is free; a new sample is taken only in IDLE.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst, synchronous): estimate 0, covariance and all three registers 0.1.
module scalar_kalman_filter_core #(
  parameter int COV_FRAC_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  skf_pkg::sample_beat_t              sample,
  output logic                               result_valid,
  input  logic                               result_ready,
  output skf_pkg::result_beat_t              result,
  input  logic                               cfg_we,
  input  logic [skf_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [skf_pkg::CovWidth-1:0]       cfg_data
);

  skf_pkg::skf_cmd_t cmd;

  skf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  skf_datapath #(
    .COV_FRAC_BITS (COV_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule
